// File: src/madt_pkg.sv
package madt_pkg;

  localparam int unsigned MAX_CPUS_DEF      = 8;
  localparam int unsigned MAX_OVERRIDES_DEF = 16;

  localparam int unsigned CPU_COUNT_W = 4;
  localparam int unsigned OVR_COUNT_W = 5;

  localparam logic [31:0] HDR_END       = 32'd44;
  localparam logic [31:0] LEN_OFS       = 32'd4;
  localparam logic [31:0] LAPIC_OFS     = 32'd36;
  localparam logic [31:0] LAPIC_DEFAULT = 32'hFEE0_0000;
  localparam logic [32:0] END_GAP       = 33'd2;

  localparam logic [7:0] ENT_LAPIC  = 8'd0;
  localparam logic [7:0] ENT_IOAPIC = 8'd1;
  localparam logic [7:0] ENT_OVR    = 8'd2;

  localparam logic [7:0] LAPIC_MIN_LEN  = 8'd8;
  localparam logic [7:0] IOAPIC_MIN_LEN = 8'd12;
  localparam logic [7:0] OVR_MIN_LEN    = 8'd10;
  localparam logic [7:0] ENTRY_MIN_LEN  = 8'd2;

  localparam logic [7:0] REL_TYPE   = 8'd0;
  localparam logic [7:0] REL_LEN    = 8'd1;
  localparam logic [7:0] REL_ID     = 8'd3;
  localparam logic [7:0] REL_WORD_A = 8'd4;
  localparam logic [7:0] REL_A_LAST = 8'd7;
  localparam logic [7:0] REL_WORD_B = 8'd8;
  localparam logic [7:0] REL_B_LAST = 8'd11;
  localparam logic [7:0] REL_FLAGS_LAST = 8'd9;

  localparam logic [31:0] REDIR_BASE     = 32'h10;
  localparam logic [15:0] REDIR_ACT_LOW  = 16'h2000;
  localparam logic [15:0] REDIR_LEVEL    = 16'h8000;
  localparam logic [3:0]  POL_MASK       = 4'h3;
  localparam logic [3:0]  TRIG_MASK      = 4'hC;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_ENTRY,
    ST_TAIL,
    ST_SCAN,
    ST_CALC,
    ST_FIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] table_byte;
    logic       start_of_table;
    logic [7:0] irq;
    logic [7:0] vector;
    logic [7:0] dest_id;
  } req_t;

  typedef struct packed {
    logic        route_ok;
    logic [31:0] redirect_index;
    logic [15:0] redirect_low;
    logic [31:0] redirect_high;
    logic [3:0]  cpu_count;
    logic        cpu_added;
    logic [7:0]  cpu_id_added;
    logic [4:0]  override_count;
    logic        ioapic_present;
    logic [31:0] ioapic_base_out;
    logic [31:0] lapic_base_out;
    logic        parse_stopped;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  src;
    logic [31:0] gsi;
    logic [15:0] flags;
  } ovr_entry_t;

endpackage

// File: src/madt_parse_irq_route_unit.sv
// channel  handshake                   payload
// in       in_valid_i / in_ready_o     in_req_i   (madt_pkg::req_t)
// out      out_valid_o / out_ready_i   out_rsp_o  (madt_pkg::rsp_t)
//
// a table byte passes through accept, header lanes and offset compare,
// entry field update, end-of-table check and result load, in that order
// a route request scans the stored overrides, one stored override
// compared per cycle through the override memory read port
// reset sets the parse state registers only; the override memory is not cleared
// a result waits in the output register; the sequencer stalls only if it is still full
module madt_parse_irq_route_unit #(
  parameter int unsigned MAX_CPUS      = madt_pkg::MAX_CPUS_DEF,
  parameter int unsigned MAX_OVERRIDES = madt_pkg::MAX_OVERRIDES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  madt_pkg::req_t  in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output madt_pkg::rsp_t  out_rsp_o
);

  localparam int unsigned CpuCw = $clog2(MAX_CPUS + 1);
  localparam int unsigned OvrAw = (MAX_OVERRIDES > 1) ? $clog2(MAX_OVERRIDES) : 1;
  localparam int unsigned OvrCw = $clog2(MAX_OVERRIDES + 1);
  localparam int unsigned OvrNw = OvrAw + 1;

  function automatic logic [31:0] put_lane(logic [31:0] w, logic [1:0] k, logic [7:0] b);
    logic [31:0] r;
    r = w;
    r[k*8 +: 8] = b;
    return r;
  endfunction

  madt_pkg::state_e state_q, state_d;

  logic [31:0] byte_offset_q, byte_offset_d;
  logic [31:0] table_length_q, table_length_d;
  logic [31:0] entry_start_q, entry_start_d;
  logic [7:0]  entry_type_q, entry_type_d;
  logic [7:0]  entry_len_q, entry_len_d;
  logic [7:0]  entry_id_q, entry_id_d;
  logic [31:0] word_a_q, word_a_d;
  logic [31:0] word_b_q, word_b_d;
  logic        stopped_q, stopped_d;
  logic [CpuCw-1:0] cpu_total_q, cpu_total_d;
  logic [31:0] ioapic_base_q, ioapic_base_d;
  logic [31:0] gsi_base_q, gsi_base_d;
  logic [OvrCw-1:0] ovr_total_q, ovr_total_d;
  logic [31:0] lapic_base_q, lapic_base_d;
  logic        walk_q, walk_d;
  logic [OvrAw-1:0] idx_q, idx_d;
  logic        out_valid_q, out_valid_d;

  madt_pkg::req_t req_q, req_d;
  logic [31:0] o_q, o_d;
  logic [7:0]  rel_q, rel_d;
  logic [31:0] gsi_q, gsi_d;
  logic [3:0]  flags_q, flags_d;
  logic [31:0] diff_q, diff_d;
  logic        ge_q, ge_d;
  logic        res_ok_q, res_ok_d;
  logic [31:0] res_idx_q, res_idx_d;
  logic [15:0] res_low_q, res_low_d;
  logic [31:0] res_high_q, res_high_d;
  logic        added_q, added_d;
  logic [7:0]  added_id_q, added_id_d;
  madt_pkg::rsp_t out_q, out_d;

  madt_pkg::ovr_entry_t ovr_mem [MAX_OVERRIDES];
  madt_pkg::ovr_entry_t rd_q;
  madt_pkg::ovr_entry_t ovr_wdata;
  logic             ovr_we;
  logic [OvrAw-1:0] rd_addr;

  logic        start;
  logic [31:0] o_cur;
  logic [31:0] es_eff;
  logic        stop_eff;
  logic [32:0] rel_diff;
  logic [7:0]  len_sel;
  logic [32:0] sum;
  logic [32:0] o_inc;
  logic [32:0] es_plus;
  logic [32:0] gsi_diff;
  logic [OvrNw-1:0] nxt;
  logic [7:0]  b;

  assign in_ready_o  = (state_q == madt_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  always_comb begin
    state_d        = state_q;
    byte_offset_d  = byte_offset_q;
    table_length_d = table_length_q;
    entry_start_d  = entry_start_q;
    entry_type_d   = entry_type_q;
    entry_len_d    = entry_len_q;
    entry_id_d     = entry_id_q;
    word_a_d       = word_a_q;
    word_b_d       = word_b_q;
    stopped_d      = stopped_q;
    cpu_total_d    = cpu_total_q;
    ioapic_base_d  = ioapic_base_q;
    gsi_base_d     = gsi_base_q;
    ovr_total_d    = ovr_total_q;
    lapic_base_d   = lapic_base_q;
    walk_d         = walk_q;
    idx_d          = idx_q;
    req_d          = req_q;
    o_d            = o_q;
    rel_d          = rel_q;
    gsi_d          = gsi_q;
    flags_d        = flags_q;
    diff_d         = diff_q;
    ge_d           = ge_q;
    res_ok_d       = res_ok_q;
    res_idx_d      = res_idx_q;
    res_low_d      = res_low_q;
    res_high_d     = res_high_q;
    added_d        = added_q;
    added_id_d     = added_id_q;
    out_d          = out_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    ovr_we         = 1'b0;
    ovr_wdata      = '{src: entry_id_q, gsi: word_a_q, flags: {req_q.table_byte, word_b_q[7:0]}};
    rd_addr        = '0;

    b        = req_q.table_byte;
    start    = req_q.start_of_table;
    o_cur    = start ? '0 : byte_offset_q;
    es_eff   = start ? madt_pkg::HDR_END : entry_start_q;
    stop_eff = start ? 1'b0 : stopped_q;
    rel_diff = {1'b0, o_cur} - {1'b0, es_eff};
    len_sel  = (rel_q == madt_pkg::REL_LEN) ? b : entry_len_q;
    sum      = {1'b0, entry_start_q} + {25'd0, len_sel};
    o_inc    = {1'b0, o_q} + 33'd1;
    es_plus  = {1'b0, entry_start_q} + madt_pkg::END_GAP;
    gsi_diff = {1'b0, gsi_q} - {1'b0, gsi_base_q};
    nxt      = {1'b0, idx_q} + OvrNw'(1);

    unique case (state_q)
      madt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          req_d      = in_req_i;
          res_ok_d   = 1'b0;
          res_idx_d  = '0;
          res_low_d  = '0;
          res_high_d = '0;
          added_d    = 1'b0;
          added_id_d = '0;
          gsi_d      = {24'd0, in_req_i.irq};
          flags_d    = '0;
          idx_d      = '0;
          if (!in_req_i.mode) begin
            state_d = madt_pkg::ST_HDR;
          end else if (ioapic_base_q != '0 && ovr_total_q != '0) begin
            state_d = madt_pkg::ST_SCAN;
          end else begin
            state_d = madt_pkg::ST_CALC;
          end
        end
      end

      madt_pkg::ST_HDR: begin
        if (start) begin
          table_length_d = '0;
          cpu_total_d    = '0;
          ovr_total_d    = '0;
          ioapic_base_d  = '0;
          gsi_base_d     = '0;
          lapic_base_d   = madt_pkg::LAPIC_DEFAULT;
        end
        entry_start_d = es_eff;
        stopped_d     = stop_eff;
        if (o_cur >= madt_pkg::LEN_OFS && o_cur <= madt_pkg::LEN_OFS + 32'd3) begin
          table_length_d = put_lane(table_length_q, o_cur[1:0], b);
        end
        if (o_cur >= madt_pkg::LAPIC_OFS && o_cur <= madt_pkg::LAPIC_OFS + 32'd3) begin
          lapic_base_d = put_lane(lapic_base_q, o_cur[1:0], b);
        end
        o_d     = o_cur;
        rel_d   = rel_diff[7:0];
        walk_d  = !stop_eff && (o_cur >= madt_pkg::HDR_END) && !rel_diff[32] &&
                  (rel_diff[31:8] == '0);
        state_d = madt_pkg::ST_ENTRY;
      end

      madt_pkg::ST_ENTRY: begin
        if (walk_q) begin
          if (rel_q == madt_pkg::REL_TYPE) begin
            entry_type_d = b;
          end else if (rel_q == madt_pkg::REL_LEN) begin
            if (b < madt_pkg::ENTRY_MIN_LEN || sum > {1'b0, table_length_q}) begin
              stopped_d = 1'b1;
            end else begin
              entry_len_d = b;
            end
          end else begin
            case (entry_type_q)
              madt_pkg::ENT_LAPIC: begin
                if (entry_len_q >= madt_pkg::LAPIC_MIN_LEN) begin
                  if (rel_q == madt_pkg::REL_ID) begin
                    entry_id_d = b;
                  end else if (rel_q >= madt_pkg::REL_WORD_A && rel_q <= madt_pkg::REL_A_LAST) begin
                    word_a_d = put_lane(word_a_q, rel_q[1:0], b);
                  end
                  if (rel_q == madt_pkg::REL_A_LAST && word_a_q[1:0] != 2'b00 &&
                      cpu_total_q < CpuCw'(MAX_CPUS)) begin
                    cpu_total_d = cpu_total_q + CpuCw'(1);
                    added_d     = 1'b1;
                    added_id_d  = entry_id_q;
                  end
                end
              end
              madt_pkg::ENT_IOAPIC: begin
                if (entry_len_q >= madt_pkg::IOAPIC_MIN_LEN) begin
                  if (rel_q >= madt_pkg::REL_WORD_A && rel_q <= madt_pkg::REL_A_LAST) begin
                    word_a_d = put_lane(word_a_q, rel_q[1:0], b);
                  end else if (rel_q >= madt_pkg::REL_WORD_B && rel_q <= madt_pkg::REL_B_LAST) begin
                    word_b_d = put_lane(word_b_q, rel_q[1:0], b);
                  end
                  if (rel_q == madt_pkg::REL_B_LAST && ioapic_base_q == '0) begin
                    ioapic_base_d = word_a_q;
                    gsi_base_d    = {b, word_b_q[23:0]};
                  end
                end
              end
              madt_pkg::ENT_OVR: begin
                if (entry_len_q >= madt_pkg::OVR_MIN_LEN) begin
                  if (rel_q == madt_pkg::REL_ID) begin
                    entry_id_d = b;
                  end else if (rel_q >= madt_pkg::REL_WORD_A && rel_q <= madt_pkg::REL_A_LAST) begin
                    word_a_d = put_lane(word_a_q, rel_q[1:0], b);
                  end else if (rel_q >= madt_pkg::REL_WORD_B &&
                               rel_q <= madt_pkg::REL_FLAGS_LAST) begin
                    word_b_d = put_lane(word_b_q, rel_q[1:0], b);
                  end
                  if (rel_q == madt_pkg::REL_FLAGS_LAST &&
                      ovr_total_q < OvrCw'(MAX_OVERRIDES)) begin
                    ovr_we      = 1'b1;
                    ovr_total_d = ovr_total_q + OvrCw'(1);
                  end
                end
              end
              default: ;
            endcase
          end
          if (!stopped_d && rel_q >= madt_pkg::REL_LEN &&
              ({1'b0, rel_q} + 9'd1) == {1'b0, entry_len_d}) begin
            entry_start_d = sum[31:0];
          end
        end
        state_d = madt_pkg::ST_TAIL;
      end

      madt_pkg::ST_TAIL: begin
        if (o_q != '1) begin
          byte_offset_d = o_inc[31:0];
        end
        if (!stopped_q && o_inc == {1'b0, entry_start_q} &&
            es_plus > {1'b0, table_length_q}) begin
          stopped_d = 1'b1;
        end
        state_d = madt_pkg::ST_DONE;
      end

      madt_pkg::ST_SCAN: begin
        if (nxt < OvrNw'(ovr_total_q)) begin
          rd_addr = nxt[OvrAw-1:0];
        end
        if (rd_q.src == req_q.irq) begin
          gsi_d   = rd_q.gsi;
          flags_d = rd_q.flags[3:0];
          state_d = madt_pkg::ST_CALC;
        end else if (nxt < OvrNw'(ovr_total_q)) begin
          idx_d = nxt[OvrAw-1:0];
        end else begin
          state_d = madt_pkg::ST_CALC;
        end
      end

      madt_pkg::ST_CALC: begin
        diff_d  = gsi_diff[31:0];
        ge_d    = !gsi_diff[32];
        state_d = madt_pkg::ST_FIN;
      end

      madt_pkg::ST_FIN: begin
        if (ioapic_base_q != '0 && ge_q) begin
          res_ok_d   = 1'b1;
          res_idx_d  = madt_pkg::REDIR_BASE + {diff_q[30:0], 1'b0};
          res_low_d  = {8'd0, req_q.vector} |
                       (((flags_q & madt_pkg::POL_MASK) == madt_pkg::POL_MASK) ?
                        madt_pkg::REDIR_ACT_LOW : 16'd0) |
                       (((flags_q & madt_pkg::TRIG_MASK) == madt_pkg::TRIG_MASK) ?
                        madt_pkg::REDIR_LEVEL : 16'd0);
          res_high_d = {req_q.dest_id, 24'd0};
        end
        state_d = madt_pkg::ST_DONE;
      end

      madt_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.route_ok        = res_ok_q;
          out_d.redirect_index  = res_idx_q;
          out_d.redirect_low    = res_low_q;
          out_d.redirect_high   = res_high_q;
          out_d.cpu_count       = madt_pkg::CPU_COUNT_W'(cpu_total_q);
          out_d.cpu_added       = added_q;
          out_d.cpu_id_added    = added_id_q;
          out_d.override_count  = madt_pkg::OVR_COUNT_W'(ovr_total_q);
          out_d.ioapic_present  = (ioapic_base_q != '0);
          out_d.ioapic_base_out = ioapic_base_q;
          out_d.lapic_base_out  = lapic_base_q;
          out_d.parse_stopped   = stopped_q;
          out_valid_d           = 1'b1;
          state_d               = madt_pkg::ST_IDLE;
        end
      end

      default: state_d = madt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= madt_pkg::ST_IDLE;
      byte_offset_q  <= '0;
      table_length_q <= '0;
      entry_start_q  <= madt_pkg::HDR_END;
      entry_type_q   <= '0;
      entry_len_q    <= '0;
      entry_id_q     <= '0;
      word_a_q       <= '0;
      word_b_q       <= '0;
      stopped_q      <= 1'b0;
      cpu_total_q    <= '0;
      ioapic_base_q  <= '0;
      gsi_base_q     <= '0;
      ovr_total_q    <= '0;
      lapic_base_q   <= madt_pkg::LAPIC_DEFAULT;
      walk_q         <= 1'b0;
      idx_q          <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      byte_offset_q  <= byte_offset_d;
      table_length_q <= table_length_d;
      entry_start_q  <= entry_start_d;
      entry_type_q   <= entry_type_d;
      entry_len_q    <= entry_len_d;
      entry_id_q     <= entry_id_d;
      word_a_q       <= word_a_d;
      word_b_q       <= word_b_d;
      stopped_q      <= stopped_d;
      cpu_total_q    <= cpu_total_d;
      ioapic_base_q  <= ioapic_base_d;
      gsi_base_q     <= gsi_base_d;
      ovr_total_q    <= ovr_total_d;
      lapic_base_q   <= lapic_base_d;
      walk_q         <= walk_d;
      idx_q          <= idx_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    o_q        <= o_d;
    rel_q      <= rel_d;
    gsi_q      <= gsi_d;
    flags_q    <= flags_d;
    diff_q     <= diff_d;
    ge_q       <= ge_d;
    res_ok_q   <= res_ok_d;
    res_idx_q  <= res_idx_d;
    res_low_q  <= res_low_d;
    res_high_q <= res_high_d;
    added_q    <= added_d;
    added_id_q <= added_id_d;
    out_q      <= out_d;
  end

  // override store
  always_ff @(posedge clk_i) begin
    if (ovr_we) begin
      ovr_mem[ovr_total_q[OvrAw-1:0]] <= ovr_wdata;
    end
    rd_q <= ovr_mem[rd_addr];
  end

endmodule

// File: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_BYTE  = 1'b0;
  localparam logic MODE_ROUTE = 1'b1;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned TARGET_ITEMS = 1250;

  typedef enum int unsigned {
    K_LAPIC,
    K_IOAPIC,
    K_OVR,
    K_UNKNOWN,
    K_SHORT,
    K_BAD
  } entry_kind_e;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  madt_pkg::req_t in_req_i;
  logic out_valid_o;
  logic out_ready_i;
  madt_pkg::rsp_t out_rsp_o;

  madt_parse_irq_route_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  // parser image
  logic [31:0] m_offset;
  logic [31:0] m_length;
  logic [31:0] m_entry_start;
  logic [7:0]  m_entry_type;
  logic [7:0]  m_entry_len;
  logic [7:0]  m_entry_id;
  logic [31:0] m_word_a;
  logic [31:0] m_word_b;
  logic        m_stopped;
  logic [7:0]  m_cpu_id [madt_pkg::MAX_CPUS_DEF];
  int unsigned m_cpu_total;
  logic [31:0] m_ioapic_base;
  logic [31:0] m_gsi_base;
  madt_pkg::ovr_entry_t m_ovr [madt_pkg::MAX_OVERRIDES_DEF];
  int unsigned m_ovr_total;
  logic [31:0] m_lapic_base;

  madt_pkg::rsp_t route_expected [$];
  madt_pkg::rsp_t rsp_want;
  logic [7:0]  madt_bytes [$];
  int unsigned items_sent;
  int unsigned mismatches;
  bit          tx_calm;
  bit          tx_rush;
  bit          rx_calm;
  bit          rx_hold_req;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #(1_500_000);
    $display("** madt_parse_irq_route_unit: FAILED **");
    $finish;
  end

  function automatic logic [31:0] put_lane(logic [31:0] w, logic [31:0] k, logic [7:0] b);
    logic [31:0] r;
    r = w;
    r[k[1:0]*8 +: 8] = b;
    return r;
  endfunction

  task automatic reset_image();
    m_offset      = '0;
    m_length      = '0;
    m_entry_start = madt_pkg::HDR_END;
    m_entry_type  = '0;
    m_entry_len   = '0;
    m_entry_id    = '0;
    m_word_a      = '0;
    m_word_b      = '0;
    m_stopped     = 1'b0;
    m_cpu_total   = 0;
    m_ioapic_base = '0;
    m_gsi_base    = '0;
    m_ovr_total   = 0;
    m_lapic_base  = madt_pkg::LAPIC_DEFAULT;
    foreach (m_cpu_id[i]) m_cpu_id[i] = '0;
    foreach (m_ovr[i]) m_ovr[i] = '0;
  endtask

  function automatic madt_pkg::rsp_t madt_step(madt_pkg::req_t r);
    madt_pkg::rsp_t o;
    logic [31:0] ofs;
    logic [31:0] rel;
    logic [31:0] gsi;
    logic [15:0] flags;
    logic [7:0]  b;
    bit          found;
    o = '0;
    b = r.table_byte;
    if (r.mode == MODE_BYTE) begin
      if (r.start_of_table) begin
        m_offset      = '0;
        m_length      = '0;
        m_entry_start = madt_pkg::HDR_END;
        m_stopped     = 1'b0;
        m_cpu_total   = 0;
        m_ovr_total   = 0;
        m_ioapic_base = '0;
        m_gsi_base    = '0;
        m_lapic_base  = madt_pkg::LAPIC_DEFAULT;
      end
      ofs = m_offset;
      if (ofs >= madt_pkg::LEN_OFS && ofs < madt_pkg::LEN_OFS + 4) begin
        m_length = put_lane(m_length, ofs - madt_pkg::LEN_OFS, b);
      end
      if (ofs >= madt_pkg::LAPIC_OFS && ofs < madt_pkg::LAPIC_OFS + 4) begin
        m_lapic_base = put_lane(m_lapic_base, ofs - madt_pkg::LAPIC_OFS, b);
      end
      if (!m_stopped && ofs >= madt_pkg::HDR_END && ofs >= m_entry_start) begin
        rel = ofs - m_entry_start;
        if (rel == madt_pkg::REL_TYPE) begin
          m_entry_type = b;
        end else if (rel == madt_pkg::REL_LEN) begin
          if (b < madt_pkg::ENTRY_MIN_LEN ||
              {1'b0, m_entry_start} + 33'(b) > {1'b0, m_length}) begin
            m_stopped = 1'b1;
          end else begin
            m_entry_len = b;
          end
        end else if (m_entry_type == madt_pkg::ENT_LAPIC &&
                     m_entry_len >= madt_pkg::LAPIC_MIN_LEN) begin
          if (rel == madt_pkg::REL_ID) m_entry_id = b;
          else if (rel >= madt_pkg::REL_WORD_A && rel <= madt_pkg::REL_A_LAST) begin
            m_word_a = put_lane(m_word_a, rel - madt_pkg::REL_WORD_A, b);
          end
          if (rel == madt_pkg::REL_A_LAST && m_word_a[1:0] != 2'b00 &&
              m_cpu_total < madt_pkg::MAX_CPUS_DEF) begin
            m_cpu_id[m_cpu_total] = m_entry_id;
            m_cpu_total++;
            o.cpu_added    = 1'b1;
            o.cpu_id_added = m_entry_id;
          end
        end else if (m_entry_type == madt_pkg::ENT_IOAPIC &&
                     m_entry_len >= madt_pkg::IOAPIC_MIN_LEN) begin
          if (rel >= madt_pkg::REL_WORD_A && rel <= madt_pkg::REL_A_LAST) begin
            m_word_a = put_lane(m_word_a, rel - madt_pkg::REL_WORD_A, b);
          end else if (rel >= madt_pkg::REL_WORD_B && rel <= madt_pkg::REL_B_LAST) begin
            m_word_b = put_lane(m_word_b, rel - madt_pkg::REL_WORD_B, b);
          end
          if (rel == madt_pkg::REL_B_LAST && m_ioapic_base == '0) begin
            m_ioapic_base = m_word_a;
            m_gsi_base    = m_word_b;
          end
        end else if (m_entry_type == madt_pkg::ENT_OVR &&
                     m_entry_len >= madt_pkg::OVR_MIN_LEN) begin
          if (rel == madt_pkg::REL_ID) m_entry_id = b;
          else if (rel >= madt_pkg::REL_WORD_A && rel <= madt_pkg::REL_A_LAST) begin
            m_word_a = put_lane(m_word_a, rel - madt_pkg::REL_WORD_A, b);
          end else if (rel >= madt_pkg::REL_WORD_B && rel <= madt_pkg::REL_FLAGS_LAST) begin
            m_word_b = put_lane(m_word_b, rel - madt_pkg::REL_WORD_B, b);
          end
          if (rel == madt_pkg::REL_FLAGS_LAST && m_ovr_total < madt_pkg::MAX_OVERRIDES_DEF) begin
            m_ovr[m_ovr_total] = '{src: m_entry_id, gsi: m_word_a, flags: m_word_b[15:0]};
            m_ovr_total++;
          end
        end
        if (!m_stopped && rel >= madt_pkg::REL_LEN && rel + 32'd1 == 32'(m_entry_len)) begin
          m_entry_start = m_entry_start + 32'(m_entry_len);
        end
      end
      if (ofs != '1) m_offset = ofs + 32'd1;
      if (!m_stopped && {1'b0, ofs} + 33'd1 == {1'b0, m_entry_start} &&
          {1'b0, m_entry_start} + madt_pkg::END_GAP > {1'b0, m_length}) begin
        m_stopped = 1'b1;
      end
    end else if (m_ioapic_base != '0) begin
      gsi   = 32'(r.irq);
      flags = '0;
      found = 1'b0;
      for (int i = 0; i < m_ovr_total; i++) begin
        if (!found && m_ovr[i].src == r.irq) begin
          gsi   = m_ovr[i].gsi;
          flags = m_ovr[i].flags;
          found = 1'b1;
        end
      end
      if (gsi >= m_gsi_base) begin
        o.route_ok       = 1'b1;
        o.redirect_index = madt_pkg::REDIR_BASE + (gsi - m_gsi_base) * 32'd2;
        o.redirect_low   = {8'h00, r.vector};
        if ((flags[3:0] & madt_pkg::POL_MASK) == madt_pkg::POL_MASK) begin
          o.redirect_low = o.redirect_low | madt_pkg::REDIR_ACT_LOW;
        end
        if ((flags[3:0] & madt_pkg::TRIG_MASK) == madt_pkg::TRIG_MASK) begin
          o.redirect_low = o.redirect_low | madt_pkg::REDIR_LEVEL;
        end
        o.redirect_high  = {r.dest_id, 24'h000000};
      end
    end
    o.cpu_count       = 4'(m_cpu_total);
    o.override_count  = 5'(m_ovr_total);
    o.ioapic_present  = (m_ioapic_base != '0);
    o.ioapic_base_out = m_ioapic_base;
    o.lapic_base_out  = m_lapic_base;
    o.parse_stopped   = m_stopped;
    return o;
  endfunction

  task automatic send_req(madt_pkg::req_t r);
    int unsigned gap;
    gap = (tx_calm || tx_rush) ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    route_expected.push_back(madt_step(r));
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b, logic start);
    madt_pkg::req_t r;
    r.mode           = MODE_BYTE;
    r.table_byte     = b;
    r.start_of_table = start;
    r.irq            = 8'($urandom);
    r.vector         = 8'($urandom);
    r.dest_id        = 8'($urandom);
    send_req(r);
  endtask

  task automatic send_route(logic [7:0] irq, logic [7:0] vec, logic [7:0] dest);
    madt_pkg::req_t r;
    r.mode           = MODE_ROUTE;
    r.table_byte     = 8'($urandom);
    r.start_of_table = 1'($urandom);
    r.irq            = irq;
    r.vector         = vec;
    r.dest_id        = dest;
    send_req(r);
  endtask

  task automatic send_noise(int unsigned n);
    madt_pkg::req_t r;
    repeat (n) begin
      r.mode           = 1'($urandom_range(0, 1));
      r.table_byte     = 8'($urandom);
      r.start_of_table = ($urandom_range(0, 3) == 0);
      r.irq            = 8'($urandom);
      r.vector         = 8'($urandom);
      r.dest_id        = 8'($urandom);
      send_req(r);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic build_table(int unsigned n_ent, bit full);
    logic [7:0]  ent [$];
    logic [31:0] len;
    logic [31:0] w;
    int unsigned pick;
    int unsigned elen;
    entry_kind_e kind;
    madt_bytes.delete();
    repeat (madt_pkg::HDR_END) madt_bytes.push_back(8'($urandom));
    for (int e = 0; e < n_ent; e++) begin
      if (full) begin
        kind = (e == 0) ? K_IOAPIC : (e <= 10) ? K_LAPIC : K_OVR;
      end else begin
        pick = $urandom_range(0, 99);
        kind = (pick < 30) ? K_LAPIC : (pick < 45) ? K_IOAPIC : (pick < 80) ? K_OVR :
               (pick < 88) ? K_UNKNOWN : (pick < 96) ? K_SHORT : K_BAD;
      end
      case (kind)
        K_LAPIC:   elen = madt_pkg::LAPIC_MIN_LEN +
                          (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
        K_IOAPIC:  elen = madt_pkg::IOAPIC_MIN_LEN +
                          (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
        K_OVR:     elen = madt_pkg::OVR_MIN_LEN +
                          (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
        K_UNKNOWN: elen = $urandom_range(2, 16);
        K_SHORT:   elen = $urandom_range(madt_pkg::ENTRY_MIN_LEN, madt_pkg::OVR_MIN_LEN + 1);
        default:   elen = $urandom_range(0, 1);
      endcase
      ent.delete();
      repeat ((elen < 2) ? 2 : elen) ent.push_back(8'($urandom));
      ent[1] = 8'(elen);
      case (kind)
        K_LAPIC: begin
          ent[0] = madt_pkg::ENT_LAPIC;
          if (full) ent[4][0] = 1'b1;
        end
        K_IOAPIC: begin
          ent[0] = madt_pkg::ENT_IOAPIC;
          w = ($urandom_range(0, 7) == 0 && !full) ? 32'd0 : $urandom;
          for (int k = 0; k < 4; k++) ent[4 + k] = w[8*k +: 8];
          w = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 8) : $urandom;
          for (int k = 0; k < 4; k++) ent[8 + k] = w[8*k +: 8];
        end
        K_OVR: begin
          ent[0] = madt_pkg::ENT_OVR;
          ent[3] = 8'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 15) : $urandom);
          w = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 40) : $urandom;
          for (int k = 0; k < 4; k++) ent[4 + k] = w[8*k +: 8];
        end
        K_UNKNOWN: ent[0] = 8'($urandom_range(madt_pkg::ENT_OVR + 1, 255));
        K_SHORT: begin
          if (elen < madt_pkg::LAPIC_MIN_LEN) begin
            ent[0] = 8'($urandom_range(madt_pkg::ENT_LAPIC, madt_pkg::ENT_OVR));
          end else if (elen < madt_pkg::OVR_MIN_LEN) begin
            ent[0] = ($urandom_range(0, 1) != 0) ? madt_pkg::ENT_OVR : madt_pkg::ENT_IOAPIC;
          end else begin
            ent[0] = madt_pkg::ENT_IOAPIC;
          end
        end
        default: ;
      endcase
      foreach (ent[k]) madt_bytes.push_back(ent[k]);
    end
    len = madt_bytes.size();
    pick = $urandom_range(0, 9);
    if (pick == 0) len = len - $urandom_range(1, 8);
    else if (pick == 1) len = len + $urandom_range(1, 8);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) madt_bytes.push_back(8'($urandom));
    for (int k = 0; k < 4; k++) madt_bytes[madt_pkg::LEN_OFS + k] = len[8*k +: 8];
    if ($urandom_range(0, 1) != 0) begin
      for (int k = 0; k < 4; k++) begin
        madt_bytes[madt_pkg::LAPIC_OFS + k] = madt_pkg::LAPIC_DEFAULT[8*k +: 8];
      end
    end
  endtask

  task automatic send_table(bit start);
    foreach (madt_bytes[i]) begin
      if ($urandom_range(0, 39) == 0) begin
        send_route(8'($urandom_range(0, 15)), 8'($urandom), 8'($urandom));
      end
      send_byte(madt_bytes[i], start && i == 0);
    end
  endtask

  task automatic send_routes(int unsigned n);
    repeat (n) begin
      send_route(8'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 15) : $urandom),
                 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_route_without_ioapic();
    send_route(8'h00, 8'h00, 8'hFF);
    send_route(8'hFF, 8'hFF, 8'h00);
    send_route(8'h09, 8'hA5, 8'h5A);
  endtask

  task automatic test_header_lanes();
    send_byte(8'hFF, 1'b1);
    for (int i = 1; i < 12; i++) begin
      send_byte((i % 2 != 0) ? 8'h00 : 8'hFF, 1'b0);
      if (i == 5) send_route(8'h01, 8'h20, 8'h01);
    end
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
  endtask

  task automatic test_full_stores();
    build_table(29, 1'b1);
    send_table(1'b1);
    for (int i = 0; i < 16; i++) send_route(8'(i), 8'($urandom), 8'($urandom));
    send_route(8'hFF, 8'hFF, 8'hFF);
  endtask

  task automatic test_random_tables();
    while (items_sent < TARGET_ITEMS - 60) begin
      if ($urandom_range(0, 5) == 0) begin
        send_noise($urandom_range(5, 20));
      end else begin
        build_table($urandom_range(1, 8), 1'b0);
        send_table($urandom_range(0, 9) != 0);
        send_routes($urandom_range(3, 10));
      end
    end
  endtask

  task automatic test_backpressure();
    rx_hold_req = 1'b1;
    tx_rush     = 1'b1;
    send_routes(30);
    send_noise(20);
    tx_rush     = 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (route_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: unexpected result %h", $realtime, out_rsp_o);
      end else begin
        rsp_want = route_expected.pop_front();
        check_field("route_ok", 32'(out_rsp_o.route_ok), 32'(rsp_want.route_ok));
        check_field("redirect_index", out_rsp_o.redirect_index, rsp_want.redirect_index);
        check_field("redirect_low", 32'(out_rsp_o.redirect_low), 32'(rsp_want.redirect_low));
        check_field("redirect_high", out_rsp_o.redirect_high, rsp_want.redirect_high);
        check_field("cpu_count", 32'(out_rsp_o.cpu_count), 32'(rsp_want.cpu_count));
        check_field("cpu_added", 32'(out_rsp_o.cpu_added), 32'(rsp_want.cpu_added));
        check_field("cpu_id_added", 32'(out_rsp_o.cpu_id_added), 32'(rsp_want.cpu_id_added));
        check_field("override_count", 32'(out_rsp_o.override_count),
                    32'(rsp_want.override_count));
        check_field("ioapic_present", 32'(out_rsp_o.ioapic_present),
                    32'(rsp_want.ioapic_present));
        check_field("ioapic_base_out", out_rsp_o.ioapic_base_out, rsp_want.ioapic_base_out);
        check_field("lapic_base_out", out_rsp_o.lapic_base_out, rsp_want.lapic_base_out);
        check_field("parse_stopped", 32'(out_rsp_o.parse_stopped), 32'(rsp_want.parse_stopped));
      end
    end
  end

  // result side: random stalls, calm stretches, one long hold on request
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        stall       = HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end else begin
        stall = rx_calm ? 0 : $urandom_range(0, 15);
      end
      if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    int unsigned waited;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    items_sent = 0;
    mismatches = 0;
    reset_image();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_route_without_ioapic();
    test_header_lanes();
    test_full_stores();
    test_random_tables();
    test_backpressure();
    settle();

    waited = 0;
    while (route_expected.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    if (route_expected.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", route_expected.size());
    end
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** madt_parse_irq_route_unit: PASSED **");
    end else begin
      $display("** madt_parse_irq_route_unit: FAILED **");
    end
    $finish;
  end

endmodule
